// File: src/dds_pkg.sv
// Shared constants for the decimal digit store adder.
// No dependencies; imported by the top level and its port checker.
`timescale 1ns / 1ps

package dds_pkg;

  // Number of decimal digits held in the store.
  localparam int DIGITS = 10;

  // Field widths of the input and result beats.
  localparam int DIG_W  = 4;
  localparam int NUM_W  = 31;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 4;
  localparam int PACK_W = 40;
  localparam int CNTO_W = 4;

  // Internal widths that follow from the store depth and the number width.
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int BIT_W  = $clog2(NUM_W);

  // Digits that appear in the packed result.
  localparam int SHOWN  = (DIGITS < 10) ? DIGITS : 10;

  // Largest value a digit or the added value may take.
  localparam logic [DIG_W-1:0] DIGIT_MAX = DIG_W'(9);

  typedef logic [DIG_W-1:0] digit_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ADD  = 1'b1;

endpackage

// File: src/decimal_digit_store_adder.sv
// Top level of the decimal digit store adder: binary load and decimal add.
// Depends on dds_pkg for widths, the store depth and the item kinds.
`timescale 1ns / 1ps

// The block keeps a store of DIGITS decimal digits and a digit count.
// Input channel (in_valid / in_ready): one beat carries kind, number,
// position and add_value. Kind load converts number to decimal and replaces
// the store; kind add adds add_value (limited to 9) at digit position and
// ripples the decimal carry upward. Every input beat yields exactly one
// result beat on the output channel (out_valid / out_ready) that carries the
// packed store, the digit count and an overflow flag.
//
// Sequencing: a load shifts number in one bit per cycle through a shift-and-
// adjust BCD converter, then scans the digits one per cycle to find the
// count. An add visits one digit per cycle from position until the carry
// dies or the top digit is passed. An add at a position outside the store
// leaves the store unchanged. Each result is registered once the output
// register is free, and the next beat can be taken in the cycle after a
// result is registered.
//
// One item is worked on at a time; in_ready is high only while the block
// waits for an item. The result sits in an output register, so the next
// item is taken while an earlier result still waits for the receiver. If the
// receiver stalls and a new result is finished, the block holds it until the
// output register frees up. Reset empties the store, clears the count and
// drops any pending result.
module decimal_digit_store_adder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [dds_pkg::NUM_W-1:0]   number,
  input  logic [dds_pkg::POS_W-1:0]   position,
  input  logic [dds_pkg::VAL_W-1:0]   add_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dds_pkg::PACK_W-1:0]  packed_digits,
  output logic [dds_pkg::CNTO_W-1:0]  digit_count,
  output logic                        overflow
);
  import dds_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state;
  digit_t           digits [DIGITS];
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] shreg;
  logic [BIT_W-1:0] bitcnt;
  logic [IDX_W-1:0] idx;
  digit_t           carry;
  logic             ovf;

  // Shift-and-adjust step of the binary to BCD converter.
  digit_t           adj     [DIGITS];
  digit_t           dd_next [DIGITS];
  logic             dd_out;

  // Digit add step.
  digit_t           cur;
  logic [DIG_W:0]   sum;
  digit_t           sum_digit;
  logic             sum_carry;
  digit_t           clamped;

  logic [PACK_W-1:0] packed_now;
  logic              fin_take;

  assign in_ready = (state == ST_IDLE);
  assign fin_take = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (digits[i] >= DIG_W'(5)) ? digits[i] + DIG_W'(3) : digits[i];
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (i == 0) begin
        dd_next[i] = {adj[i][DIG_W-2:0], shreg[NUM_W-1]};
      end else begin
        dd_next[i] = {adj[i][DIG_W-2:0], adj[i-1][DIG_W-1]};
      end
    end
    dd_out = adj[DIGITS-1][DIG_W-1];
  end

  always_comb begin
    cur = digits[idx];
    sum = {1'b0, cur} + {1'b0, carry};
    if (sum > {1'b0, DIGIT_MAX}) begin
      sum_digit = DIG_W'(sum - (DIG_W+1)'(10));
      sum_carry = 1'b1;
    end else begin
      sum_digit = sum[DIG_W-1:0];
      sum_carry = 1'b0;
    end
    clamped = (add_value > DIGIT_MAX) ? DIGIT_MAX : add_value;
  end

  always_comb begin
    packed_now = '0;
    for (int i = 0; i < SHOWN; i++) begin
      packed_now[i*DIG_W +: DIG_W] = digits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else begin
      // A finished result fills the output register when it is empty or as the old beat leaves.
      if (fin_take) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ovf <= 1'b0;
            if (kind == KIND_LOAD) begin
              for (int i = 0; i < DIGITS; i++) begin
                digits[i] <= '0;
              end
              shreg  <= number;
              bitcnt <= '0;
              state  <= ST_CONV;
            end else if (32'(position) >= 32'(DIGITS)) begin
              state <= ST_FIN;
            end else begin
              idx   <= IDX_W'(position);
              carry <= clamped;
              state <= ST_ADD;
            end
          end
        end

        ST_CONV: begin
          for (int i = 0; i < DIGITS; i++) begin
            digits[i] <= dd_next[i];
          end
          shreg <= {shreg[NUM_W-2:0], 1'b0};
          if (dd_out) begin
            ovf <= 1'b1;
          end
          if (bitcnt == BIT_W'(NUM_W - 1)) begin
            idx   <= '0;
            cnt   <= '0;
            state <= ST_SCAN;
          end else begin
            bitcnt <= bitcnt + BIT_W'(1);
          end
        end

        ST_SCAN: begin
          if (cur != '0) begin
            cnt <= CNT_W'(idx) + CNT_W'(1);
          end
          if (idx == IDX_W'(DIGITS - 1)) begin
            state <= ST_FIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        ST_ADD: begin
          digits[idx] <= sum_digit;
          // The count only grows on an add; a digit that turns nonzero
          // above the count raises it.
          if (sum_digit != '0 && (CNT_W'(idx) + CNT_W'(1)) > cnt) begin
            cnt <= CNT_W'(idx) + CNT_W'(1);
          end
          if (!sum_carry) begin
            state <= ST_FIN;
          end else if (idx == IDX_W'(DIGITS - 1)) begin
            ovf   <= 1'b1;
            state <= ST_FIN;
          end else begin
            idx   <= idx + IDX_W'(1);
            carry <= DIG_W'(1);
          end
        end

        ST_FIN: begin
          if (fin_take) begin
            packed_digits <= packed_now;
            digit_count   <= (32'(cnt) > 32'd15) ? CNTO_W'(15) : CNTO_W'(cnt);
            overflow      <= ovf;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/dds_port_checker.sv
// Port-level checker for the decimal digit store adder, bound to the top.
// Depends on dds_pkg and on the top level decimal_digit_store_adder.
`timescale 1ns / 1ps

module dds_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dds_pkg::PACK_W-1:0]  packed_digits,
  input logic [dds_pkg::CNTO_W-1:0]  digit_count,
  input logic                        overflow
);
  import dds_pkg::*;

  function automatic logic all_decimal(input logic [PACK_W-1:0] p);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < PACK_W / DIG_W; i++) begin
      if (p[i*DIG_W +: DIG_W] > DIGIT_MAX) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // A taken beat starts work, so the block is busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again without a pause");

  // Every shown digit is a decimal digit.
  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> all_decimal(packed_digits))
    else $error("packed digit above nine");

  // The count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(digit_count) <= 32'(DIGITS)))
    else $error("digit count beyond store depth");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(packed_digits)
      && $stable(digit_count) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind decimal_digit_store_adder dds_port_checker u_dds_port_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .packed_digits (packed_digits),
  .digit_count   (digit_count),
  .overflow      (overflow)
);

// File: sim/decimal_digit_store_adder_tb.sv
// Testbench for decimal_digit_store_adder: a directed table, then random load and add beats.
// Every result beat is checked against the view from the table or an in-bench model of the digit store.
// Depends on dds_pkg and the decimal_digit_store_adder RTL.
`timescale 1ns / 1ps

module decimal_digit_store_adder_tb;
  import dds_pkg::*;

  localparam int  RANDOM_ITEMS = 600;
  localparam int  DRAIN_CYCLES = 64;     // longer than the slowest load
  localparam int  SHOWN_ERRORS = 10;
  localparam time RUN_LIMIT    = 5ms;    // several times the slowest stalled run

  // One result beat as the store looks after an item.
  typedef struct packed {
    logic [PACK_W-1:0] bcd;
    logic [CNTO_W-1:0] count;
    logic              ovf;
  } store_view_t;

  // One row of the directed table. When typed is set, the expected view is
  // taken from the row; otherwise the model of the store supplies it.
  typedef struct packed {
    logic              kind;
    logic [NUM_W-1:0]  number;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic              typed;
    store_view_t       view;
  } table_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              kind;
  logic [NUM_W-1:0]  number;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  add_value;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PACK_W-1:0] packed_digits;
  logic [CNTO_W-1:0] digit_count;
  logic              overflow;

  decimal_digit_store_adder DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .number        (number),
    .position      (position),
    .add_value     (add_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packed_digits (packed_digits),
    .digit_count   (digit_count),
    .overflow      (overflow)
  );

  // Model of the block's state: the digit store and its digit count.
  digit_t      model_digits [DIGITS];
  int unsigned model_count;

  // Views the block still owes, oldest first.
  store_view_t pending_views [$];
  table_row_t  directed_rows [$];

  int unsigned fail_count = 0;
  int unsigned beats_checked = 0;
  int unsigned overflow_beats = 0;
  int unsigned load_items;
  int unsigned add_items;
  int unsigned ignored_items;
  int unsigned burst_left;

  // Receiver pacing state.
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Index of the highest nonzero digit plus one, or zero for an empty store.
  function automatic int unsigned top_digit_count();
    int unsigned c;
    c = 0;
    for (int i = 0; i < DIGITS; i++) begin
      if (model_digits[i] != 0) begin
        c = i + 1;
      end
    end
    return c;
  endfunction

  // Applies one item to the model and returns the view the block must show.
  function automatic store_view_t apply_to_store(input logic k, input logic [NUM_W-1:0] n,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [VAL_W-1:0] v);
    int unsigned rest;
    int unsigned carry;
    int unsigned s;
    int unsigned top;
    logic        ovf;
    store_view_t r;
    ovf = 1'b0;
    if (k == KIND_LOAD) begin
      // Repeated division by ten; whatever is left after the top digit is lost.
      rest = n;
      for (int i = 0; i < DIGITS; i++) begin
        model_digits[i] = digit_t'(rest % 10);
        rest = rest / 10;
      end
      ovf = (rest != 0);
      model_count = top_digit_count();
    end else if (p < DIGITS) begin
      // The added value is limited to one decimal digit, then carried upward.
      carry = (v > DIGIT_MAX) ? DIGIT_MAX : v;
      for (int i = p; i < DIGITS && carry != 0; i++) begin
        s = model_digits[i] + carry;
        if (s > DIGIT_MAX) begin
          s = s - 10;
          carry = 1;
        end else begin
          carry = 0;
        end
        model_digits[i] = digit_t'(s);
      end
      ovf = (carry != 0);
      top = top_digit_count();
      if (top > model_count) begin
        model_count = top;
      end
    end
    r.bcd = '0;
    for (int i = 0; i < SHOWN; i++) begin
      r.bcd[DIG_W*i +: DIG_W] = model_digits[i];
    end
    r.count = (model_count > 15) ? CNTO_W'(15) : CNTO_W'(model_count);
    r.ovf   = ovf;
    return r;
  endfunction

  task automatic put_row(input logic k, input logic [NUM_W-1:0] n, input logic [POS_W-1:0] p,
                         input logic [VAL_W-1:0] v, input logic typed,
                         input logic [PACK_W-1:0] x_bcd, input logic [CNTO_W-1:0] x_count,
                         input logic x_ovf);
    table_row_t row;
    row.kind       = k;
    row.number     = n;
    row.pos        = p;
    row.val        = v;
    row.typed      = typed;
    row.view.bcd   = x_bcd;
    row.view.count = x_count;
    row.view.ovf   = x_ovf;
    directed_rows.push_back(row);
  endtask

  // The sender works in bursts. At the end of a burst valid drops for a random
  // gap, so pauses land on every phase of the block's work.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  // Presents one input beat, holds it until it is taken, then records the
  // view that the block must return for it.
  task automatic send_beat(input logic k, input logic [NUM_W-1:0] n, input logic [POS_W-1:0] p,
                           input logic [VAL_W-1:0] v, input logic typed,
                           input store_view_t typed_view);
    store_view_t predicted;
    pace_sender();
    in_valid  <= 1'b1;
    kind      <= k;
    number    <= n;
    position  <= p;
    add_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_store(k, n, p, v);
    pending_views.push_back(typed ? typed_view : predicted);
    if (k == KIND_LOAD) begin
      load_items++;
    end else if (p < DIGITS) begin
      add_items++;
    end else begin
      ignored_items++;
    end
  endtask

  task automatic report_failure(input string what, input store_view_t want);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) begin
      $display("%0t: %s: expected bcd=%h count=%0d ovf=%0b, got bcd=%h count=%0d ovf=%0b",
               $time, what, want.bcd, want.count, want.ovf,
               packed_digits, digit_count, overflow);
    end
  endtask

  // Receiver: ready follows a pattern that is picked anew at random, from
  // always ready through sparse ready to long stalls. Result beats are
  // checked at the same edge at which they are taken.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(16, 64);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= (rx_phase % 32 == 0);
      end
    endcase

    if (!rst && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        report_failure("result beat with nothing pending", '0);
      end else begin
        if (packed_digits !== pending_views[0].bcd ||
            digit_count !== pending_views[0].count ||
            overflow !== pending_views[0].ovf) begin
          report_failure("mismatch", pending_views[0]);
        end
        if (pending_views[0].ovf) begin
          overflow_beats++;
        end
        void'(pending_views.pop_front());
        beats_checked++;
      end
    end
  end

  initial begin
    logic              k;
    logic [NUM_W-1:0]  n;
    logic [POS_W-1:0]  p;
    logic [VAL_W-1:0]  v;
    int unsigned       roll;
    int unsigned       span;
    int unsigned       useful;

    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_LOAD;
    number       = '0;
    position     = '0;
    add_value    = '0;
    load_items   = 0;
    add_items    = 0;
    ignored_items = 0;
    burst_left   = 0;
    for (int i = 0; i < DIGITS; i++) begin
      model_digits[i] = '0;
    end
    model_count = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Rows with an obvious answer carry it; the rest lean on
    // the model. The store state runs on from row to row.
    put_row(KIND_ADD,  0,          0,  0,  1, 40'h0,          0,  0); // empty store after reset
    put_row(KIND_LOAD, 0,          0,  0,  1, 40'h0,          0,  0); // zero loads as count zero
    put_row(KIND_LOAD, 2147483647, 0,  0,  1, 40'h2147483647, 10, 0); // largest number
    put_row(KIND_ADD,  0,          9,  9,  1, 40'h1147483647, 10, 1); // carry out of the top
    put_row(KIND_ADD,  0,          15, 5,  1, 40'h1147483647, 10, 0); // position off the store
    put_row(KIND_ADD,  0,          10, 15, 1, 40'h1147483647, 10, 0); // first position past top
    put_row(KIND_LOAD, 5,          0,  0,  1, 40'h5,          1,  0); // load clears upper digits
    put_row(KIND_ADD,  0,          0,  15, 0, '0, 0, 0);              // value limited to nine
    put_row(KIND_ADD,  0,          3,  7,  0, '0, 0, 0);              // count grows on add
    put_row(KIND_ADD,  0,          8,  0,  0, '0, 0, 0);              // adding zero
    put_row(KIND_LOAD, 999999999,  0,  0,  0, '0, 0, 0);
    put_row(KIND_ADD,  0,          0,  1,  0, '0, 0, 0);              // ripple to the top digit
    put_row(KIND_LOAD, 1999999999, 0,  0,  1, 40'h1999999999, 10, 0);
    put_row(KIND_ADD,  0,          9,  8,  0, '0, 0, 0);              // all nines
    put_row(KIND_ADD,  0,          0,  1,  1, 40'h0,          10, 1); // full ripple, count kept
    put_row(KIND_LOAD, 0,          0,  0,  1, 40'h0,          0,  0);
    put_row(KIND_ADD,  0,          9,  1,  0, '0, 0, 0);              // add at the top digit
    put_row(KIND_LOAD, 1073741824, 0,  0,  0, '0, 0, 0);
    put_row(KIND_LOAD, 1431655765, 0,  0,  0, '0, 0, 0);
    put_row(KIND_LOAD, 715827882,  0,  0,  0, '0, 0, 0);
    put_row(KIND_ADD,  0,          7,  12, 0, '0, 0, 0);
    put_row(KIND_ADD,  0,          1,  9,  0, '0, 0, 0);
    put_row(KIND_ADD,  0,          14, 0,  0, '0, 0, 0);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].kind, directed_rows[i].number, directed_rows[i].pos,
                directed_rows[i].val, directed_rows[i].typed, directed_rows[i].view);
    end

    // Random part. Mostly adds at low positions so that carries ripple far,
    // with loads of every length, runs of nines, and a few ignored positions.
    // Beats at ignored positions do not count toward the total.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      k = KIND_ADD;
      n = NUM_W'($urandom);
      p = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 3))
                                      : POS_W'($urandom_range(0, 9));
      v = VAL_W'($urandom_range(0, 9));
      if (roll < 12) begin
        k = KIND_LOAD;
        span = 1;
        repeat ($urandom_range(1, 9)) span = span * 10;
        n = NUM_W'($urandom % span);
      end else if (roll < 17) begin
        k = KIND_LOAD;
        span = 1;
        repeat ($urandom_range(1, 9)) span = span * 10;
        n = NUM_W'(span - 1);
      end else if (roll < 22) begin
        k = KIND_LOAD;
      end else if (roll < 30) begin
        p = POS_W'($urandom_range(DIGITS, 15));
        v = VAL_W'($urandom_range(0, 15));
      end else if (roll < 40) begin
        v = VAL_W'($urandom_range(10, 15));
      end
      if (k == KIND_LOAD || p < DIGITS) begin
        useful++;
      end
      send_beat(k, n, p, v, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d adds and %0d adds off the store.",
             load_items, add_items, ignored_items);
    $display("Checked %0d result beats, %0d of them flagged overflow; %0d failures.",
             beats_checked, overflow_beats, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Ends a run that hangs on a handshake.
  initial begin
    #RUN_LIMIT;
    $display("Run limit reached with %0d results outstanding.", pending_views.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/dds_pkg.sv
src/decimal_digit_store_adder.sv
src/dds_port_checker.sv
sim/decimal_digit_store_adder_tb.sv
